@@ hw/rtl/tcgw_pkg.sv @@
// Shared types and codes for the text console glyph writer.
`timescale 1ns / 1ps
package tcgw_pkg;

  // Input opcodes carried on s_tuser
  localparam logic [1:0] OP_PUT_CHAR  = 2'd0;
  localparam logic [1:0] OP_LOAD_FONT = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  // Result commands carried on m_tuser
  localparam logic [1:0] CMD_ROW    = 2'd0;
  localparam logic [1:0] CMD_SCROLL = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  // Item kinds passed from the front end to the back end
  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_CLEAR   = 3'd1;
  localparam logic [2:0] KIND_NEWLINE = 3'd2;
  localparam logic [2:0] KIND_TAB     = 3'd3;
  localparam logic [2:0] KIND_PRINT   = 3'd4;

  // Control characters
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_LINE_LO  = 8'd10;
  localparam logic [7:0] CH_LINE_HI  = 8'd13;

  localparam int CHAR_W      = 8;
  localparam int GROW_W      = 4;
  localparam int BITS_W      = 8;
  localparam int BPP_W       = 3;
  localparam int OFFSET_W    = 19;
  localparam int MASK_W      = 8;
  localparam int GLYPH_PIX   = 8;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd2;
  localparam logic [BPP_W-1:0] BPP_MIN   = 3'd1;
  localparam logic [BPP_W-1:0] BPP_MAX   = 3'd4;

  typedef struct packed {
    logic [2:0]        kind;
    logic              blank;     // printable code outside the font
    logic [CHAR_W-1:0] char_code;
    logic [GROW_W-1:0] glyph_row;
    logic [BITS_W-1:0] row_bits;
  } cls_item_t;

endpackage

@@ hw/rtl/tcgw_front.sv @@
// Front end: input register, item decode and drop of items with no effect.
`timescale 1ns / 1ps
module tcgw_front import tcgw_pkg::*; #(
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output cls_item_t            q_item
);

  logic      held;
  cls_item_t item;
  cls_item_t cls;
  logic      keep;

  logic [CHAR_W-1:0] ch;
  logic [GROW_W-1:0] grow;
  logic              ch_in_font;

  assign ch   = s_tdata[CHAR_W-1:0];
  assign grow = s_tdata[CHAR_W +: GROW_W];
  assign ch_in_font = 32'(ch) < GLYPH_COUNT;

  always_comb begin
    cls.kind      = KIND_PRINT;
    cls.blank     = !ch_in_font;
    cls.char_code = ch;
    cls.glyph_row = grow;
    cls.row_bits  = s_tdata[CHAR_W+GROW_W +: BITS_W];
    keep          = 1'b0;
    unique case (s_tuser)
      OP_PUT_CHAR: begin
        keep = 1'b1;
        if (ch >= CH_LINE_LO && ch <= CH_LINE_HI) begin
          cls.kind = KIND_NEWLINE;
        end else if (ch == CH_TAB) begin
          cls.kind = KIND_TAB;
        end else begin
          cls.kind = KIND_PRINT;
        end
      end
      OP_LOAD_FONT: begin
        cls.kind = KIND_LOAD;
        keep     = ch_in_font && (32'(grow) < GLYPH_HEIGHT);
      end
      OP_CLEAR: begin
        cls.kind = KIND_CLEAR;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign q_push   = held && !q_full;
  assign s_tready = !held || !q_full;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= keep;
    end else if (q_push) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= cls;
    end
  end

endmodule

@@ hw/rtl/tcgw_fifo.sv @@
// Short queue of decoded items between the front end and the back end.
`timescale 1ns / 1ps
module tcgw_fifo import tcgw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cls_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      avail,
  output cls_item_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  cls_item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNTW-1:0]   count;

  assign full  = count == CNTW'(QUEUE_DEPTH);
  assign avail = count != '0;
  assign head  = slots[rd_ptr];

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/tcgw_back.sv @@
// Back end: cursor, font memory, result sequencer and output register.
`timescale 1ns / 1ps
module tcgw_back import tcgw_pkg::*; #(
  parameter int SCREEN_WIDTH = 240,
  parameter int TEXT_COLUMNS = 30,
  parameter int TEXT_ROWS    = 20,
  parameter int GLYPH_HEIGHT = 16,
  parameter int TAB_WIDTH    = 4,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [BPP_W-1:0]      cfg_wdata,
  input  logic                  q_avail,
  input  cls_item_t             q_head,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [1:0]            m_tuser,
  output logic                  m_tlast
);

  localparam int CW   = $clog2(TEXT_COLUMNS + 1);
  localparam int RW   = $clog2(TEXT_ROWS + 1);
  localparam int GIW  = $clog2(GLYPH_COUNT);
  localparam int AW   = $clog2(GLYPH_COUNT * GLYPH_HEIGHT);
  localparam int GHW  = $clog2(GLYPH_HEIGHT);
  localparam int TABW = CW + 5;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCROLL = 3'd1;
  localparam logic [2:0] ST_CLEAR  = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_SUM    = 3'd4;
  localparam logic [2:0] ST_ROWS   = 3'd5;

  logic [2:0]          state;
  logic [CW-1:0]       col;
  logic [RW-1:0]       row;
  logic [BPP_W-1:0]    bpp;
  logic [OFFSET_W-1:0] pitch;
  logic                scroll_last;
  logic                blank;
  logic [AW-1:0]       glyph_base;
  logic [GHW-1:0]      cnt;
  logic [OFFSET_W-1:0] line_prod;
  logic [OFFSET_W-1:0] col_prod;
  logic [OFFSET_W-1:0] off;
  logic [MASK_W-1:0]   font [GLYPH_COUNT * GLYPH_HEIGHT];
  logic [MASK_W-1:0]   rd_data;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       wr_addr;

  logic              out_free;
  logic              emit_row;
  logic              at_bottom;
  logic              wrap;
  logic              draws;
  logic [TABW-1:0]   tab_col;
  logic [AW-1:0]     head_base;

  assign out_free  = !m_tvalid || m_tready;
  assign q_pop     = (state == ST_IDLE) && q_avail;
  assign emit_row  = (state == ST_ROWS) && out_free;
  assign at_bottom = row == RW'(TEXT_ROWS - 1);
  assign wrap      = 32'(col) >= TEXT_COLUMNS;
  assign draws     = (bpp >= BPP_MIN) && (bpp <= BPP_MAX) && !blank;
  assign tab_col   = TABW'(col) + TABW'(TAB_WIDTH);
  assign head_base = AW'(AW'(q_head.char_code[GIW-1:0]) * AW'(GLYPH_HEIGHT));
  assign wr_addr   = head_base + AW'(q_head.glyph_row);
  // Keep the read one row ahead so rd_data always holds the row about to go out
  assign rd_addr   = glyph_base + AW'(cnt) + AW'(emit_row);

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == KIND_LOAD) begin
      font[wr_addr] <= q_head.row_bits;
    end
    rd_data <= font[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bpp <= BPP_RESET;
    end else if (cfg_we) begin
      bpp <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    pitch <= OFFSET_W'(OFFSET_W'(bpp) * OFFSET_W'(SCREEN_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      col      <= '0;
      row      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // Load a new result whenever the output register is free in an emitting state
      if (out_free) begin
        m_tvalid <= (state == ST_SCROLL) || (state == ST_CLEAR) || (state == ST_ROWS);
      end
      unique case (state)
        ST_IDLE: begin
          if (q_avail) begin
            unique case (q_head.kind)
              KIND_CLEAR: begin
                col   <= '0;
                row   <= '0;
                state <= ST_CLEAR;
              end
              KIND_NEWLINE: begin
                col <= '0;
                if (at_bottom) begin
                  state <= ST_SCROLL;
                end else begin
                  row <= row + RW'(1);
                end
              end
              KIND_TAB: begin
                col <= (32'(tab_col) > TEXT_COLUMNS) ? CW'(TEXT_COLUMNS)
                                                    : CW'(tab_col);
              end
              KIND_PRINT: begin
                state <= (wrap && at_bottom) ? ST_SCROLL : ST_SETUP;
                if (wrap) begin
                  col <= '0;
                  if (!at_bottom) begin
                    row <= row + RW'(1);
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (out_free) begin
            state <= scroll_last ? ST_IDLE : ST_SETUP;
          end
        end
        ST_CLEAR: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        ST_SETUP: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          state <= ST_ROWS;
        end
        ST_ROWS: begin
          if (out_free) begin
            if (cnt == GHW'(GLYPH_HEIGHT - 1)) begin
              col   <= col + CW'(1);
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath and payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      scroll_last <= q_head.kind == KIND_NEWLINE;
      blank       <= q_head.blank;
      glyph_base  <= head_base;
    end
    if (state == ST_SETUP) begin
      line_prod <= OFFSET_W'(OFFSET_W'(OFFSET_W'(row) * OFFSET_W'(GLYPH_HEIGHT)) * pitch);
      col_prod  <= OFFSET_W'(OFFSET_W'(col) * OFFSET_W'(bpp) * OFFSET_W'(GLYPH_PIX));
      cnt       <= '0;
    end
    if (state == ST_SUM) begin
      off <= line_prod + col_prod;
    end
    if (emit_row) begin
      off <= off + pitch;
      cnt <= cnt + GHW'(1);
    end
    if (state == ST_SCROLL && out_free) begin
      m_tuser <= CMD_SCROLL;
      m_tdata <= '0;
      m_tlast <= scroll_last;
    end
    if (state == ST_CLEAR && out_free) begin
      m_tuser <= CMD_CLEAR;
      m_tdata <= '0;
      m_tlast <= 1'b1;
    end
    if (emit_row) begin
      m_tuser <= CMD_ROW;
      m_tdata <= {(OUT_DATA_W - OFFSET_W - MASK_W)'(0),
                  (draws ? rd_data : MASK_W'(0)), off};
      m_tlast <= cnt == GHW'(GLYPH_HEIGHT - 1);
    end
  end

endmodule

@@ hw/rtl/text_console_glyph_writer_top.sv @@
// Top level of the text console glyph writer.
//
//   channel  | group                        | transfer carries
//   ---------+------------------------------+-----------------------------------
//   input    | s_tvalid s_tready s_tdata    | opcode on s_tuser; char_code,
//            | s_tuser                      | glyph_row, row_bits on s_tdata
//   output   | m_tvalid m_tready m_tdata    | command on m_tuser, last on m_tlast;
//            | m_tuser m_tlast              | byte_offset, pixel_mask on m_tdata
//   config   | cfg_we cfg_wdata             | bytes_per_pixel, written when cfg_we
//
// A printed character is popped from the queue, then its line and column
// products are formed, then their sum, then one glyph row goes out per cycle
// while the output is ready, paced by the single read port of the font memory
// and the output register. A print that wraps on the bottom row first emits a
// scroll. Font loads, tabs and line feeds are handled as they are popped; a
// line feed on the bottom row also emits a scroll, and a clear emits one result.
// Reset (rst, synchronous) homes the cursor, sets bytes_per_pixel to 2 and
// empties the queue; the font memory holds no reset value.
// The front end keeps accepting while the back end is stalled on m_tready,
// until the two-entry queue and the input register are full.
`timescale 1ns / 1ps
module text_console_glyph_writer_top import tcgw_pkg::*; #(
  parameter int SCREEN_WIDTH = 240,
  parameter int TEXT_COLUMNS = 30,
  parameter int TEXT_ROWS    = 20,
  parameter int GLYPH_HEIGHT = 16,
  parameter int TAB_WIDTH    = 4,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [BPP_W-1:0]      cfg_wdata,  // bytes_per_pixel
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,    // char_code, glyph_row, row_bits, zero pad
  input  logic [1:0]            s_tuser,    // opcode
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,    // byte_offset, pixel_mask, zero pad
  output logic [1:0]            m_tuser,    // command
  output logic                  m_tlast
);

  // Front end to queue
  logic      q_full;
  logic      q_push;
  cls_item_t q_in;
  // Queue to back end
  logic      q_avail;
  logic      q_pop;
  cls_item_t q_head;

  // Decode and drop opcode 3 and out-of-range font loads here
  tcgw_front #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // Decouple decode from the result sequencer
  tcgw_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .head      (q_head)
  );

  // Execute items in order: font writes, cursor moves and result emission
  tcgw_back #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .TEXT_COLUMNS (TEXT_COLUMNS),
    .TEXT_ROWS    (TEXT_ROWS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .TAB_WIDTH    (TAB_WIDTH),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_avail   (q_avail),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ hw/rtl/tcgw_checker.sv @@
// Port-level checks for the text console glyph writer, bound to the top level.
`timescale 1ns / 1ps
module tcgw_checker import tcgw_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser,
  input logic                  m_tlast
);

  // Hold a stalled result unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != CMD_ROW |-> m_tdata == '0)
    else $error("scroll or clear carries nonzero data");

  a_clear_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == CMD_CLEAR |-> m_tlast)
    else $error("clear result not marked last");

endmodule

bind text_console_glyph_writer_top tcgw_checker u_tcgw_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the text console glyph writer.
`timescale 1ns / 1ps
module tb_top import tcgw_pkg::*;;

  // Console geometry, kept in step with the block's default parameters
  localparam int LINE_PIXELS = 240;
  localparam int COLS        = 30;
  localparam int ROWS        = 20;
  localparam int GLYPH_H     = 16;
  localparam int TAB_STEP    = 4;

  // Opcode the block must ignore
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int NO_CHECK        = -1;
  localparam int TAIL_CYCLES     = 40;
  localparam int OUT_HOLD_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 13;
  localparam int PHASES          = 6;
  localparam int PRELOAD_COUNT   = 3;
  localparam longint RUN_LIMIT_NS = 10_000_000;

  // One glyph-row write, scroll or clear as it leaves the block
  typedef struct packed {
    logic [1:0]          cmd;
    logic [OFFSET_W-1:0] offset;
    logic [MASK_W-1:0]   mask;
    logic                last;
  } glyph_result_t;

  // One directed transfer; n_typed = NO_CHECK leaves it to the predictor alone
  typedef struct packed {
    logic [1:0]          op;
    logic [7:0]          ch;
    logic [3:0]          grow;
    logic [7:0]          bits;
    int                  n_typed;
    logic [1:0]          cmd_typed;
    logic [OFFSET_W-1:0] off_typed;
  } console_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [BPP_W-1:0]      cfg_wdata;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [1:0]            m_tuser;
  logic                  m_tlast;

  text_console_glyph_writer_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop in case the block hangs
  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: cursor, bytes_per_pixel and a copy of the font
  // ---------------------------------------------------------------------------
  int               cursor_col;
  int               cursor_row;
  logic [BPP_W-1:0] bpp_copy;
  logic [7:0]       font_copy [256][GLYPH_H];
  logic [15:0]      rows_loaded [256];
  bit               glyph_ready [256];
  logic [7:0]       ready_glyphs [$];   // glyphs with all rows loaded, safe to print

  glyph_result_t    pending_results [$];
  int               mismatch_count;

  // Handshake pacing shared between the stimulus and the output side
  bit               in_no_idle;
  bit               out_no_idle;
  bit               out_hold_req;
  bit               out_xfer;
  int               hold_left;
  int               gap_left;

  logic [7:0] preload_glyphs [PRELOAD_COUNT] = '{8'd0, 8'd65, 8'd255};
  logic [BPP_W-1:0] bpp_plan [PHASES] = '{3'd4, 3'd1, 3'd0, 3'd7, 3'd3, 3'd5};

  // Directed part, run with bytes_per_pixel at its reset value of 2 and the
  // cursor home: one column is 16 bytes, one text line 16 * 480 bytes.
  console_row_t directed_rows [24] = '{
    '{OP_PUT_CHAR,  8'd65,  4'd0,  8'd0,   16,       CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd255, 4'd0,  8'd0,   16,       CMD_ROW,   19'd16},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd0,   4'd0,  8'd0,   16,       CMD_ROW,   19'd96},
    '{OP_PUT_CHAR,  8'd65,  4'd0,  8'd0,   NO_CHECK, CMD_ROW,   19'd0},
    '{OP_RESERVED,  8'd255, 4'd15, 8'd255, 0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd10,  4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd11,  4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd12,  4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd13,  4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    // eighth tab saturates the column at the line end
    '{OP_PUT_CHAR,  CH_TAB, 4'd0,  8'd0,   0,        CMD_ROW,   19'd0},
    // past the line end: wrap to line 5 before drawing
    '{OP_PUT_CHAR,  8'd65,  4'd0,  8'd0,   16,       CMD_ROW,   19'd38400},
    '{OP_LOAD_FONT, 8'd65,  4'd3,  8'h5A,  0,        CMD_ROW,   19'd0},
    '{OP_PUT_CHAR,  8'd65,  4'd0,  8'd0,   NO_CHECK, CMD_ROW,   19'd0},
    '{OP_CLEAR,     8'd0,   4'd0,  8'd0,   1,        CMD_CLEAR, 19'd0},
    '{OP_PUT_CHAR,  8'd255, 4'd0,  8'd0,   16,       CMD_ROW,   19'd0},
    '{OP_RESERVED,  8'd0,   4'd0,  8'd0,   0,        CMD_ROW,   19'd0}
  };

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("tb: mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic void push_result(input logic [1:0] cmd, input int offset,
                                      input logic [7:0] mask, input logic last);
    glyph_result_t r;
    r.cmd    = cmd;
    r.offset = offset[OFFSET_W-1:0];   // byte offset wraps to its field width
    r.mask   = mask;
    r.last   = last;
    pending_results.push_back(r);
  endfunction

  // Move down one text line; at the bottom row hold the row and emit a scroll
  task automatic advance_line(input logic is_last, inout int n);
    cursor_row++;
    if (cursor_row >= ROWS) begin
      cursor_row = ROWS - 1;
      push_result(CMD_SCROLL, 0, 8'd0, is_last);
      n++;
    end
  endtask

  // Apply one accepted transfer to the predictor and queue the results it causes
  task automatic console_step(input logic [1:0] op, input logic [7:0] ch,
                              input logic [3:0] grow, input logic [7:0] bits,
                              output int n);
    int offset;
    int bpp;
    logic [7:0] mask;
    n   = 0;
    bpp = int'(bpp_copy);
    case (op)
      OP_LOAD_FONT: begin
        font_copy[ch][grow] = bits;
        rows_loaded[ch][grow] = 1'b1;
        if (&rows_loaded[ch] && !glyph_ready[ch]) begin
          glyph_ready[ch] = 1'b1;
          ready_glyphs.push_back(ch);
        end
      end
      OP_CLEAR: begin
        cursor_col = 0;
        cursor_row = 0;
        push_result(CMD_CLEAR, 0, 8'd0, 1'b1);
        n = 1;
      end
      OP_PUT_CHAR: begin
        if (ch >= CH_LINE_LO && ch <= CH_LINE_HI) begin
          advance_line(1'b1, n);
          cursor_col = 0;
        end else if (ch == CH_TAB) begin
          cursor_col = (cursor_col + TAB_STEP > COLS) ? COLS : cursor_col + TAB_STEP;
        end else begin
          // wrap on at-or-past the line end, so a saturated tab wraps too
          if (cursor_col >= COLS) begin
            advance_line(1'b0, n);
            cursor_col = 0;
          end
          for (int i = 0; i < GLYPH_H; i++) begin
            offset = (cursor_row * GLYPH_H + i) * bpp * LINE_PIXELS
                   + cursor_col * GLYPH_PIX * bpp;
            // unsupported pixel sizes draw nothing but still place the row
            mask = (bpp_copy >= BPP_MIN && bpp_copy <= BPP_MAX) ? font_copy[ch][i] : 8'd0;
            push_result(CMD_ROW, offset, mask, i == GLYPH_H - 1);
            n++;
          end
          cursor_col++;
        end
      end
      default: ;  // reserved opcode: no result, no state change
    endcase
  endtask

  // Offer one transfer after a random gap, wait for the handshake, then predict
  task automatic send_item(input logic [1:0] op, input logic [7:0] ch,
                           input logic [3:0] grow, input logic [7:0] bits,
                           output int n, output glyph_result_t head);
    int gap;
    gap = in_no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_DATA_W - 20){1'b0}}, bits, grow, ch};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    console_step(op, ch, grow, bits, n);
    head = (n > 0) ? pending_results[pending_results.size() - n] : '0;
    @(negedge clk);
  endtask

  // Drop valid, drain every expected result, then give the block time to
  // finish work that causes no result (font loads, tabs)
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_bpp(input logic [BPP_W-1:0] value);
    cfg_wdata <= value;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    bpp_copy  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: per-transfer random stall, plus one long hold on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_hold_req) begin
        out_hold_req = 1'b0;
        hold_left    = OUT_HOLD_CYCLES;
      end
      if (out_xfer) begin
        out_xfer = 1'b0;
        gap_left = out_no_idle ? 0 : $urandom_range(0, 5);
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Compare each output transfer with the oldest expectation, field by field
  always @(posedge clk) begin : result_check
    glyph_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      out_xfer = 1'b1;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result cmd %0d data %h", m_tuser, m_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_tuser !== want.cmd)
          flag_mismatch($sformatf("command got %0d want %0d", m_tuser, want.cmd));
        if (m_tdata[OFFSET_W-1:0] !== want.offset)
          flag_mismatch($sformatf("byte_offset got %0d want %0d",
                                  m_tdata[OFFSET_W-1:0], want.offset));
        if (m_tdata[OFFSET_W+MASK_W-1:OFFSET_W] !== want.mask)
          flag_mismatch($sformatf("pixel_mask got %h want %h",
                                  m_tdata[OFFSET_W+MASK_W-1:OFFSET_W], want.mask));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("last got %b want %b", m_tlast, want.last));
        if (m_tdata[OUT_DATA_W-1:OFFSET_W+MASK_W] !== '0)
          flag_mismatch($sformatf("tdata pad not zero: %h", m_tdata));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int            n;
    int            sel;
    int            counted;
    glyph_result_t head;
    logic [1:0]    op;
    logic [7:0]    ch;
    logic [7:0]    g;
    logic [3:0]    grow;
    logic [7:0]    bits;
    bit            long_lines;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = OP_PUT_CHAR;
    cursor_col     = 0;
    cursor_row     = 0;
    bpp_copy       = BPP_RESET;
    mismatch_count = 0;
    for (int k = 0; k < 256; k++) begin
      rows_loaded[k] = '0;
      glyph_ready[k] = 1'b0;
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Load whole glyphs first so that no print ever reads an unloaded font row.
    // Glyph 0 gets a walking bit, glyph 255 all-ones under an empty top row.
    for (int k = 0; k < PRELOAD_COUNT; k++) begin
      g = preload_glyphs[k];
      for (int r = 0; r < GLYPH_H; r++) begin
        if (g == 8'd0)
          bits = 8'h01 << r[2:0];
        else if (g == 8'd255)
          bits = (r == 0) ? 8'h00 : 8'hFF;
        else
          bits = 8'($urandom);
        send_item(OP_LOAD_FONT, g, r[3:0], bits, n, head);
      end
    end

    // Directed walk; typed rows also cross-check the predictor's own result
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].grow,
                directed_rows[i].bits, n, head);
      if (directed_rows[i].n_typed != NO_CHECK) begin
        if (n != directed_rows[i].n_typed)
          flag_mismatch($sformatf("row %0d: %0d results predicted, %0d typed",
                                  i, n, directed_rows[i].n_typed));
        else if (n > 0 && (head.cmd !== directed_rows[i].cmd_typed ||
                           head.offset !== directed_rows[i].off_typed))
          flag_mismatch($sformatf("row %0d: first result cmd %0d off %0d, typed %0d %0d",
                                  i, head.cmd, head.offset,
                                  directed_rows[i].cmd_typed, directed_rows[i].off_typed));
      end
    end

    // Random phases, each under its own bytes_per_pixel. Even phases are
    // newline heavy so the cursor reaches the bottom and scrolls; odd phases
    // run long lines so prints wrap, scrolling first when on the last row.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_bpp(bpp_plan[p]);
      long_lines  = p[0];
      in_no_idle  = (p == 2);
      out_no_idle = (p == 2);
      // back-pressure burst: output held off while input keeps offering
      if (p == 2)
        out_hold_req = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        sel  = $urandom_range(0, 99);
        ch   = 8'($urandom);
        grow = 4'($urandom);
        bits = 8'($urandom);
        op   = OP_PUT_CHAR;
        if (sel < 1)
          op = OP_CLEAR;
        else if (sel < 5)
          op = OP_RESERVED;
        else if (sel < 17)
          op = OP_LOAD_FONT;
        else if (sel < (long_lines ? 32 : 27))
          ch = CH_TAB;
        else if (sel < (long_lines ? 35 : 90))
          ch = 8'($urandom_range(CH_LINE_LO, CH_LINE_HI));
        else
          ch = ready_glyphs[$urandom_range(0, ready_glyphs.size() - 1)];
        send_item(op, ch, grow, bits, n, head);
        if (op != OP_RESERVED)
          counted++;
      end
    end

    in_no_idle  = 1'b0;
    out_no_idle = 1'b0;
    settle();

    if (mismatch_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/tcgw_pkg.sv
hw/rtl/tcgw_front.sv
hw/rtl/tcgw_fifo.sv
hw/rtl/tcgw_back.sv
hw/rtl/text_console_glyph_writer_top.sv
hw/rtl/tcgw_checker.sv
tb/sv/tb_top.sv
